// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// implication checked in the cycle after the antecedent, outside reset
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- design/bbf_pkg.sv -----
// ----------------------------------------------------------------------------
// bbf_pkg
// types, constants and helper functions of the blocked bloom filter table
// ----------------------------------------------------------------------------
package bbf_pkg;

   // store geometry
   localparam int MAX_WORDS_LOG2_DEF = 10;
   localparam int WORD_W             = 64;
   localparam int HASH_W             = 64;
   localparam int SIZE_W             = 4;
   localparam int GROUP_W            = 6;
   localparam int NUM_GROUPS         = 4;
   localparam int INDEX_LSB          = 24;

   localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = 4'd10;

   // operation codes
   localparam logic FUNC_PROBE  = 1'b0;
   localparam logic FUNC_INSERT = 1'b1;

   // sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RMW
   } state_type;

   // one bit per 6-bit hash group, four groups from bit 0 up
   function automatic logic [WORD_W-1:0] mask_of(input logic [HASH_W-1:0] h);
      logic [WORD_W-1:0] m;
      m = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         m = m | (WORD_W'(1) << h[g*GROUP_W +: GROUP_W]);
      end
      return m;
   endfunction

endpackage

// ----- design/bbf_ram.sv -----
// ----------------------------------------------------------------------------
// bbf_ram
// generic single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
module bbf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/blocked_bloom_filter_table_top.sv -----
// ----------------------------------------------------------------------------
// blocked_bloom_filter_table_top
// blocked bloom filter over a store of 64-bit words, insert and probe
// ----------------------------------------------------------------------------
//  channel   direction  handshake                       payload
//  req_      in         start && !busy                  req_func, req_hash_code
//  rsp_      out        rsp_valid, one cycle, no stall  rsp_hit
//  csr_      in         csr_valid && csr_ready          csr_size_log2
//
//  every item is a read of the single-port word store, then the modify and
//  write back (insert) or the hit compare (probe)
//  a probe's result shows in the rmw state; busy holds off the next item
//  after reset a clearing pass zeroes all 2**MAX_WORDS_LOG2 words of the store
//  (1024 by default), with busy high; csr writes are taken at all times
//  the receiver cannot stall, so results never wait
// ----------------------------------------------------------------------------
module blocked_bloom_filter_table_top #(
   parameter int MAX_WORDS_LOG2 = bbf_pkg::MAX_WORDS_LOG2_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // item in
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic [bbf_pkg::HASH_W-1:0]    req_hash_code,
   // result out
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   // size register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bbf_pkg::SIZE_W-1:0]    csr_size_log2
);

   localparam int DEPTH = 1 << MAX_WORDS_LOG2;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EFF_W = 5;

   bbf_pkg::state_type state_ff, state_in;

   logic [bbf_pkg::SIZE_W-1:0] size_log2_ff;
   logic [AW-1:0]              clr_addr_ff, clr_addr_in;
   logic [AW-1:0]              index_ff;
   logic [bbf_pkg::WORD_W-1:0] mask_ff;
   logic                       func_ff;

   logic [EFF_W-1:0]           size_eff;
   logic [AW-1:0]              sel;
   logic [AW-1:0]              req_index;
   logic                       accept;

   logic                       ram_we;
   logic [AW-1:0]              ram_addr;
   logic [bbf_pkg::WORD_W-1:0] ram_wdata;
   logic [bbf_pkg::WORD_W-1:0] ram_rdata;

   // size register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_log2_ff <= bbf_pkg::SIZE_LOG2_RESET;
      end else if (csr_valid && csr_ready) begin
         size_log2_ff <= csr_size_log2;
      end
   end

   // word index: hash bits from 24 up, masked to the saturated size
   always_comb begin
      size_eff = (EFF_W'(size_log2_ff) > EFF_W'(MAX_WORDS_LOG2)) ?
                 EFF_W'(MAX_WORDS_LOG2) : EFF_W'(size_log2_ff);
      for (int i = 0; i < AW; i++) begin
         sel[i] = (EFF_W'(i) < size_eff);
      end
      req_index = req_hash_code[bbf_pkg::INDEX_LSB +: AW] & sel;
   end

   assign accept = start && !busy;

   // state and clear counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bbf_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // item payload held through the read-modify-write
   always_ff @(posedge clock) begin
      if (accept) begin
         index_ff <= req_index;
         mask_ff  <= bbf_pkg::mask_of(req_hash_code);
         func_ff  <= req_func;
      end
   end

   // next state, memory port and result
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      busy        = 1'b1;
      ram_we      = 1'b0;
      ram_addr    = req_index;
      ram_wdata   = '0;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         bbf_pkg::ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_addr    = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = bbf_pkg::ST_IDLE;
            end
         end
         bbf_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               state_in = bbf_pkg::ST_RMW;
            end
         end
         bbf_pkg::ST_RMW: begin
            ram_addr  = index_ff;
            ram_wdata = ram_rdata | mask_ff;
            ram_we    = (func_ff == bbf_pkg::FUNC_INSERT);
            rsp_valid = (func_ff == bbf_pkg::FUNC_PROBE);
            state_in  = bbf_pkg::ST_IDLE;
         end
         default: begin
            state_in = bbf_pkg::ST_IDLE;
         end
      endcase
   end

   // hit when every mask bit is already set
   assign rsp_hit = ((ram_rdata & mask_ff) == mask_ff);

   // filter word store
   bbf_ram #(
      .WIDTH (bbf_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

endmodule

// ----- design/bbf_checker.sv -----
// ----------------------------------------------------------------------------
// bbf_checker
// port-level checks of the blocked bloom filter table sequencing
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbf_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_func,
   input logic rsp_valid,
   input logic csr_valid,
   input logic csr_ready
);

   logic item_taken;
   logic probe_taken;
   logic insert_taken;

   // accepted items by operation
   assign item_taken   = start && !busy;
   assign probe_taken  = item_taken && (req_func == bbf_pkg::FUNC_PROBE);
   assign insert_taken = item_taken && (req_func == bbf_pkg::FUNC_INSERT);

   // a probe answers in the following cycle
   `ASSERT_NEXT(a_probe_result, clock, reset, probe_taken, rsp_valid, "probe gave no result")

   // an insert never answers
   `ASSERT_NEXT(a_insert_silent, clock, reset, insert_taken, !rsp_valid, "insert gave a result")

   // an item in flight blocks the next one
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, item_taken, busy, "not busy after an item")

   // a result only follows an accepted probe
   `ASSERT_IMPLY(a_result_has_item, clock, reset, rsp_valid, $past(probe_taken), "stray result")

   // the size register is always writable
   `ASSERT_IMPLY(a_csr_ready, clock, reset, csr_valid, csr_ready, "size register write refused")

endmodule

bind blocked_bloom_filter_table_top bbf_checker u_bbf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_func  (req_func),
   .rsp_valid (rsp_valid),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);

// ----- sim/tb_blocked_bloom_filter_table_top.sv -----
// ----------------------------------------------------------------------------
// tb_blocked_bloom_filter_table_top
// drives probes and inserts into the blocked bloom filter table through
// several word-count settings, tracks a shadow copy of the filter words and
// checks every hit flag against it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_blocked_bloom_filter_table_top;

   localparam int MAX_LOG2      = bbf_pkg::MAX_WORDS_LOG2_DEF;
   localparam int NUM_WORDS     = 1 << MAX_LOG2;
   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_LIMIT   = 4 * NUM_WORDS + 400;
   localparam int ITEMS_PER_RUN = 78;
   localparam int RECENT_MAX    = 48;

   // shadow of the filter words plus the queue of hit flags still to come
   class bloom_tracker;
      logic [bbf_pkg::WORD_W-1:0] shadow_words [NUM_WORDS];
      logic [bbf_pkg::SIZE_W-1:0] size_log2;
      logic                       hits_due [$];
      int                         errors;

      function new();
         foreach (shadow_words[i]) shadow_words[i] = '0;
         size_log2 = bbf_pkg::SIZE_LOG2_RESET;
         errors    = 0;
      endfunction

      function void set_size(logic [bbf_pkg::SIZE_W-1:0] v);
         size_log2 = v;
      endfunction

      // one bit set per 6-bit group, groups may land on the same bit
      function logic [bbf_pkg::WORD_W-1:0] bit_mask(logic [bbf_pkg::HASH_W-1:0] h);
         logic [bbf_pkg::WORD_W-1:0] m;
         m = '0;
         for (int g = 0; g < bbf_pkg::NUM_GROUPS; g++) begin
            m[h[g*bbf_pkg::GROUP_W +: bbf_pkg::GROUP_W]] = 1'b1;
         end
         return m;
      endfunction

      // word index, oversized settings saturate to the store size
      function int unsigned word_sel(logic [bbf_pkg::HASH_W-1:0] h);
         int unsigned                used;
         logic [bbf_pkg::HASH_W-1:0] sel;
         used = (size_log2 > MAX_LOG2) ? MAX_LOG2 : size_log2;
         sel  = (64'd1 << used) - 64'd1;
         return int'((h >> bbf_pkg::INDEX_LSB) & sel);
      endfunction

      function void take_item(logic f, logic [bbf_pkg::HASH_W-1:0] h);
         logic [bbf_pkg::WORD_W-1:0] m;
         int unsigned                ix;
         m  = bit_mask(h);
         ix = word_sel(h);
         if (f == bbf_pkg::FUNC_INSERT) begin
            shadow_words[ix] = shadow_words[ix] | m;
         end else begin
            hits_due.push_back((shadow_words[ix] & m) == m);
         end
      endfunction

      function void check_hit(logic hit);
         logic want;
         if (hits_due.size() == 0) begin
            $error("hit result with no probe outstanding: actual %0b", hit);
            errors++;
         end else begin
            want = hits_due.pop_front();
            if (hit !== want) begin
               $error("hit mismatch: expected %0b, actual %0b", want, hit);
               errors++;
            end
         end
      endfunction

      function int outstanding();
         return hits_due.size();
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic                         req_func;
   logic [bbf_pkg::HASH_W-1:0]   req_hash_code;
   logic                         rsp_valid;
   logic                         rsp_hit;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [bbf_pkg::SIZE_W-1:0]   csr_size_log2;

   bloom_tracker                 tracker;
   int                           quiet_cycles = 0;
   logic [bbf_pkg::HASH_W-1:0]   recent_keys [$];

   blocked_bloom_filter_table_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_hash_code (req_hash_code),
      .rsp_valid     (rsp_valid),
      .rsp_hit       (rsp_hit),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_size_log2 (csr_size_log2)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // monitor: results first, then the item and size write taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) tracker.check_hit(rsp_hit);
         if (start && !busy) tracker.take_item(req_func, req_hash_code);
         if (csr_valid && csr_ready) tracker.set_size(csr_size_log2);
         if (rsp_valid || (start && !busy) || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // watchdog on cycles without any handshake
   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("blocked_bloom_filter_table_top test failed");
      $finish;
   end

   function automatic logic [bbf_pkg::HASH_W-1:0] make_key(logic [39:0] upper,
                                                           logic [5:0] g3,
                                                           logic [5:0] g2,
                                                           logic [5:0] g1,
                                                           logic [5:0] g0);
      return {upper, g3, g2, g1, g0};
   endfunction

   function automatic logic [bbf_pkg::HASH_W-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   // present one item and hold it until taken
   task automatic push_item(logic f, logic [bbf_pkg::HASH_W-1:0] h);
      @(negedge clock);
      start         <= 1'b1;
      req_func      <= f;
      req_hash_code <= h;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause_req(int unsigned cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // block goes quiet: no probe outstanding and the last insert written back
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(logic [bbf_pkg::SIZE_W-1:0] v);
      if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, 18)) @(negedge clock);
      @(negedge clock);
      csr_valid     <= 1'b1;
      csr_size_log2 <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly insert-then-probe traffic, plus random probes and collided groups
   task automatic run_random(int count, int gap_pct);
      int                         pick;
      int                         k;
      logic                       f;
      logic [bbf_pkg::HASH_W-1:0] h;
      logic [5:0]                 grp;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            f = bbf_pkg::FUNC_INSERT;
            h = random_key();
            recent_keys.push_back(h);
            if (recent_keys.size() > RECENT_MAX) void'(recent_keys.pop_front());
         end else if (pick < 65 && recent_keys.size() > 0) begin
            f = bbf_pkg::FUNC_PROBE;
            h = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            // near miss: disturb one mask group bit
            if ($urandom_range(0, 9) == 0) begin
               k    = $urandom_range(0, bbf_pkg::INDEX_LSB - 1);
               h[k] = ~h[k];
            end
         end else if (pick < 90) begin
            f = bbf_pkg::FUNC_PROBE;
            h = random_key();
         end else begin
            // all four groups on the same bit
            f        = 1'($urandom_range(0, 1));
            h        = random_key();
            grp      = 6'($urandom_range(0, 63));
            h[23:0]  = {4{grp}};
         end
         push_item(f, h);
         if ($urandom_range(0, 99) < gap_pct) pause_req($urandom_range(1, 18));
      end
   endtask

   initial begin
      logic [bbf_pkg::SIZE_W-1:0] plan [9];
      int                         gap_pct;

      tracker       = new();
      plan          = '{4'd3, 4'd10, 4'd0, 4'd12, 4'd6, 4'd1, 4'd15, 4'd8, 4'd10};
      reset         = 1'b1;
      start         = 1'b0;
      req_func      = bbf_pkg::FUNC_PROBE;
      req_hash_code = '0;
      csr_valid     = 1'b0;
      csr_size_log2 = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty store, both extremes of the hash, at the reset size
      push_item(bbf_pkg::FUNC_PROBE, '0);
      push_item(bbf_pkg::FUNC_INSERT, '0);
      push_item(bbf_pkg::FUNC_PROBE, '0);
      push_item(bbf_pkg::FUNC_PROBE, '1);
      push_item(bbf_pkg::FUNC_INSERT, '1);
      push_item(bbf_pkg::FUNC_PROBE, '1);
      // all groups on one bit, then one group off
      push_item(bbf_pkg::FUNC_INSERT, make_key(40'd7, 6'd5, 6'd5, 6'd5, 6'd5));
      push_item(bbf_pkg::FUNC_PROBE, make_key(40'd7, 6'd5, 6'd5, 6'd5, 6'd5));
      push_item(bbf_pkg::FUNC_PROBE, make_key(40'd7, 6'd5, 6'd5, 6'd5, 6'd6));
      // distinct groups, probes with a subset and with a missing bit
      push_item(bbf_pkg::FUNC_INSERT, make_key(40'd300, 6'd1, 6'd20, 6'd42, 6'd63));
      push_item(bbf_pkg::FUNC_PROBE, make_key(40'd300, 6'd63, 6'd42, 6'd20, 6'd20));
      push_item(bbf_pkg::FUNC_PROBE, make_key(40'd300, 6'd63, 6'd42, 6'd20, 6'd19));
      // upper hash bits beyond the index are ignored
      push_item(bbf_pkg::FUNC_PROBE,
                make_key(40'hFF_FFFF_FD2C, 6'd1, 6'd20, 6'd42, 6'd63));

      // single word in use, store keeps its contents
      settle();
      write_size(4'd0);
      push_item(bbf_pkg::FUNC_PROBE, make_key(40'd513, 6'd0, 6'd0, 6'd0, 6'd0));
      push_item(bbf_pkg::FUNC_INSERT,
                make_key(40'hFF_FFFF_FFFF, 6'd33, 6'd34, 6'd35, 6'd36));
      push_item(bbf_pkg::FUNC_PROBE, make_key(40'd2, 6'd36, 6'd35, 6'd34, 6'd33));

      // oversized setting acts as the full store
      settle();
      write_size(4'd15);
      push_item(bbf_pkg::FUNC_PROBE, '1);
      push_item(bbf_pkg::FUNC_PROBE,
                make_key(40'hFF_FFFF_FC07, 6'd5, 6'd5, 6'd5, 6'd5));
      push_item(bbf_pkg::FUNC_PROBE, make_key(40'd7, 6'd33, 6'd33, 6'd33, 6'd33));

      // random runs, one per size setting, no gaps in the last one
      foreach (plan[p]) begin
         settle();
         write_size(plan[p]);
         recent_keys.delete();
         case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 20;
            default: gap_pct = 45;
         endcase
         if (p == 8) gap_pct = 0;
         run_random(ITEMS_PER_RUN, gap_pct);
      end

      settle();
      if (tracker.errors == 0) begin
         $display("blocked_bloom_filter_table_top test passed");
      end else begin
         $display("blocked_bloom_filter_table_top test failed");
      end
      $finish;
   end

endmodule
